[src/ppcd_pkg.sv]
`timescale 1ns / 1ps

package ppcd_pkg;

  localparam int unsigned FrameWidthDefault  = 256;
  localparam int unsigned FrameHeightDefault = 240;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned PalW   = 6;

  // mask bit positions
  localparam int unsigned MaskGrey  = 0;
  localparam int unsigned MaskEmphR = 5;
  localparam int unsigned MaskEmphG = 6;
  localparam int unsigned MaskEmphB = 7;

  // weighted sums and scaled channels stay below 2**15
  localparam int unsigned WideW = 15;

  localparam logic [WideW-1:0] LumaR     = 15'd30;
  localparam logic [WideW-1:0] LumaG     = 15'd59;
  localparam logic [WideW-1:0] LumaB     = 15'd11;
  localparam logic [WideW-1:0] GainBoost = 15'd115;
  localparam logic [WideW-1:0] GainCut   = 15'd85;
  localparam logic [ChanW-1:0] ChanMax   = 8'd255;

  // x / 100 for x < 2**15 as (x * 5243) >> 19
  localparam int unsigned       Div100W     = 13;
  localparam logic [Div100W-1:0] Div100Mul  = 13'd5243;
  localparam int unsigned       Div100Shift = 19;
  localparam int unsigned       Div100ProdW = WideW + Div100W;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CodeW-1:0] code_t;
  typedef logic [ChanW-1:0] chan_t;
  typedef logic [MaskW-1:0] mask_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  function automatic rgb_t palette_lookup(input logic [PalW-1:0] code);
    rgb_t c;
    case (code)
      6'd0:  c = '{8'd84,  8'd84,  8'd84};
      6'd1:  c = '{8'd0,   8'd30,  8'd116};
      6'd2:  c = '{8'd8,   8'd16,  8'd144};
      6'd3:  c = '{8'd48,  8'd0,   8'd136};
      6'd4:  c = '{8'd68,  8'd0,   8'd100};
      6'd5:  c = '{8'd92,  8'd0,   8'd48};
      6'd6:  c = '{8'd84,  8'd4,   8'd0};
      6'd7:  c = '{8'd60,  8'd24,  8'd0};
      6'd8:  c = '{8'd32,  8'd42,  8'd0};
      6'd9:  c = '{8'd8,   8'd58,  8'd0};
      6'd10: c = '{8'd0,   8'd64,  8'd0};
      6'd11: c = '{8'd0,   8'd60,  8'd0};
      6'd12: c = '{8'd0,   8'd50,  8'd60};
      6'd13: c = '{8'd0,   8'd0,   8'd0};
      6'd14: c = '{8'd0,   8'd0,   8'd0};
      6'd15: c = '{8'd0,   8'd0,   8'd0};
      6'd16: c = '{8'd152, 8'd150, 8'd152};
      6'd17: c = '{8'd8,   8'd76,  8'd196};
      6'd18: c = '{8'd48,  8'd50,  8'd236};
      6'd19: c = '{8'd92,  8'd30,  8'd228};
      6'd20: c = '{8'd136, 8'd20,  8'd176};
      6'd21: c = '{8'd160, 8'd20,  8'd100};
      6'd22: c = '{8'd152, 8'd34,  8'd32};
      6'd23: c = '{8'd120, 8'd60,  8'd0};
      6'd24: c = '{8'd84,  8'd90,  8'd0};
      6'd25: c = '{8'd40,  8'd114, 8'd0};
      6'd26: c = '{8'd8,   8'd124, 8'd0};
      6'd27: c = '{8'd0,   8'd118, 8'd40};
      6'd28: c = '{8'd0,   8'd102, 8'd120};
      6'd29: c = '{8'd0,   8'd0,   8'd0};
      6'd30: c = '{8'd0,   8'd0,   8'd0};
      6'd31: c = '{8'd0,   8'd0,   8'd0};
      6'd32: c = '{8'd236, 8'd238, 8'd236};
      6'd33: c = '{8'd76,  8'd154, 8'd236};
      6'd34: c = '{8'd120, 8'd124, 8'd236};
      6'd35: c = '{8'd176, 8'd98,  8'd236};
      6'd36: c = '{8'd228, 8'd84,  8'd236};
      6'd37: c = '{8'd236, 8'd88,  8'd180};
      6'd38: c = '{8'd236, 8'd106, 8'd100};
      6'd39: c = '{8'd212, 8'd136, 8'd32};
      6'd40: c = '{8'd160, 8'd170, 8'd0};
      6'd41: c = '{8'd116, 8'd196, 8'd0};
      6'd42: c = '{8'd76,  8'd208, 8'd32};
      6'd43: c = '{8'd56,  8'd204, 8'd108};
      6'd44: c = '{8'd56,  8'd180, 8'd204};
      6'd45: c = '{8'd60,  8'd60,  8'd60};
      6'd46: c = '{8'd0,   8'd0,   8'd0};
      6'd47: c = '{8'd0,   8'd0,   8'd0};
      6'd48: c = '{8'd236, 8'd238, 8'd236};
      6'd49: c = '{8'd168, 8'd204, 8'd236};
      6'd50: c = '{8'd188, 8'd188, 8'd236};
      6'd51: c = '{8'd212, 8'd178, 8'd236};
      6'd52: c = '{8'd236, 8'd174, 8'd236};
      6'd53: c = '{8'd236, 8'd174, 8'd212};
      6'd54: c = '{8'd236, 8'd180, 8'd176};
      6'd55: c = '{8'd228, 8'd196, 8'd144};
      6'd56: c = '{8'd204, 8'd210, 8'd120};
      6'd57: c = '{8'd180, 8'd222, 8'd120};
      6'd58: c = '{8'd168, 8'd226, 8'd144};
      6'd59: c = '{8'd152, 8'd226, 8'd180};
      6'd60: c = '{8'd160, 8'd214, 8'd228};
      6'd61: c = '{8'd160, 8'd162, 8'd160};
      6'd62: c = '{8'd0,   8'd0,   8'd0};
      6'd63: c = '{8'd0,   8'd0,   8'd0};
      default: c = '0;
    endcase
    return c;
  endfunction

  // truncated x / 100 for x < 2**15
  function automatic logic [8:0] div100(input logic [WideW-1:0] x);
    logic [Div100ProdW-1:0] p;
    p = Div100ProdW'(x) * Div100ProdW'(Div100Mul);
    return p[Div100Shift +: 9];
  endfunction

endpackage

[src/ppcd_if.sv]
`timescale 1ns / 1ps

interface ppcd_pix_if import ppcd_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t write_address;
  code_t color_code;

  modport source (output valid, output write_address, output color_code, input ready);
  modport sink   (input valid, input write_address, input color_code, output ready);
endinterface

interface ppcd_rgb_if import ppcd_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t target_pixel;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output target_pixel, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input target_pixel, input red, input green, input blue,
                  output ready);
endinterface

interface ppcd_cfg_if import ppcd_pkg::*; ();
  logic  valid;
  logic  ready;
  mask_t display_mask;

  modport source (output valid, output display_mask, input ready);
  modport sink   (input valid, input display_mask, output ready);
endinterface

[src/palette_pixel_color_decoder_core.sv]
`timescale 1ns / 1ps
// Channel  Role    Payload
// pix_i    sink    write_address, color_code
// res_o    source  target_pixel, red, green, blue
// cfg_i    sink    display_mask (always ready)
//
// One transfer per clock in and out while res_o.ready is high.
// Four register stages: address reciprocal multiply and palette/luma, quotient
// multiply and luma divide, remainder and channel gain, correction and divide.
// Reset clears the stage valid bits and the display mask.
// A stall on res_o fills empty stages first; pix_i.ready drops only when all are full.

module palette_pixel_color_decoder_core import ppcd_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FrameWidthDefault,
  parameter int unsigned FRAME_HEIGHT = FrameHeightDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ppcd_pix_if.sink       pix_i,
  ppcd_rgb_if.source     res_o,
  ppcd_cfg_if.sink       cfg_i
);

  localparam int unsigned Stages = 4;
  localparam int unsigned Area   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AreaW  = AddrW + 1;
  localparam logic [AreaW-1:0] AreaC = AreaW'(Area);
  localparam int unsigned RecipW = 2 * AddrW + 1;
  localparam logic [63:0] RecipFull = (64'd1 << (2 * AddrW)) / 64'(Area);
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];
  localparam int unsigned ProdW  = AddrW + RecipW;
  localparam int unsigned QaW    = AddrW + AreaW;

  logic [Stages-1:0] valid_q, valid_d, adv;
  mask_t mask_q;

  addr_t             addr1_q, addr2_q;
  logic [ProdW-1:0]  prod1_q;
  rgb_t              rgb1_q, rgb2_q, chan3_q;
  logic [WideW-1:0]  luma1_q;
  addr_t             qa2_q, rem3_q, idx4_q;
  chan_t             grey2_q;
  logic [WideW-1:0]  sr3_q, sg3_q, sb3_q;
  rgb_t              out4_q;

  rgb_t              rgb1_d, chan3_d, out4_d;
  logic [WideW-1:0]  luma1_d;
  logic [QaW-1:0]    qa2_full;
  addr_t             idx4_d;
  logic              emph_any;
  logic [8:0]        qr, qg, qb;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_i.valid) begin
      mask_q <= cfg_i.display_mask;
    end
  end

  always_comb begin
    adv[Stages-1] = !valid_q[Stages-1] || res_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d[0] = adv[0] ? pix_i.valid : valid_q[0];
    for (int k = 1; k < Stages; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  assign pix_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stage 1: reciprocal multiply, palette and luma sum
  always_comb begin
    rgb1_d  = palette_lookup(pix_i.color_code[PalW-1:0]);
    luma1_d = WideW'(rgb1_d.r) * LumaR + WideW'(rgb1_d.g) * LumaG
            + WideW'(rgb1_d.b) * LumaB;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      addr1_q <= pix_i.write_address;
      prod1_q <= ProdW'(pix_i.write_address) * ProdW'(Recip);
      rgb1_q  <= rgb1_d;
      luma1_q <= luma1_d;
    end
  end

  // stage 2: quotient times area, grey level
  assign qa2_full = QaW'(prod1_q[2*AddrW +: AddrW]) * QaW'(AreaC);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      addr2_q <= addr1_q;
      qa2_q   <= qa2_full[AddrW-1:0];
      rgb2_q  <= rgb1_q;
      grey2_q <= ChanW'(div100(luma1_q));
    end
  end

  // stage 3: raw remainder, channel select and gain
  assign emph_any = mask_q[MaskEmphR] || mask_q[MaskEmphG] || mask_q[MaskEmphB];

  always_comb begin
    if (mask_q[MaskGrey]) begin
      chan3_d = '{grey2_q, grey2_q, grey2_q};
    end else begin
      chan3_d = rgb2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      rem3_q  <= addr2_q - qa2_q;
      chan3_q <= chan3_d;
      sr3_q   <= WideW'(chan3_d.r) * (mask_q[MaskEmphR] ? GainBoost : GainCut);
      sg3_q   <= WideW'(chan3_d.g) * (mask_q[MaskEmphG] ? GainBoost : GainCut);
      sb3_q   <= WideW'(chan3_d.b) * (mask_q[MaskEmphB] ? GainBoost : GainCut);
    end
  end

  // stage 4: remainder correction; divide and saturate when any emphasis bit is set, else pass the channels
  always_comb begin
    qr = div100(sr3_q);
    qg = div100(sg3_q);
    qb = div100(sb3_q);
    if (AreaW'(rem3_q) >= AreaC) begin
      idx4_d = AddrW'(AreaW'(rem3_q) - AreaC);
    end else begin
      idx4_d = rem3_q;
    end
    if (emph_any) begin
      out4_d.r = qr[8] ? ChanMax : qr[ChanW-1:0];
      out4_d.g = qg[8] ? ChanMax : qg[ChanW-1:0];
      out4_d.b = qb[8] ? ChanMax : qb[ChanW-1:0];
    end else begin
      out4_d = chan3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      idx4_q <= idx4_d;
      out4_q <= out4_d;
    end
  end

  assign res_o.valid        = valid_q[Stages-1];
  assign res_o.target_pixel = idx4_q;
  assign res_o.red          = out4_q.r;
  assign res_o.green        = out4_q.g;
  assign res_o.blue         = out4_q.b;

`ifndef ASSERT_OFF
  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> AreaW'(res_o.target_pixel) < AreaC)
    else $error("pixel index outside frame");

  a_grey_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && mask_q[MaskGrey] && !emph_any) |->
      (res_o.red == res_o.green && res_o.green == res_o.blue))
    else $error("grey output channels differ");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (&valid_q && !res_o.ready))
    else $error("input held back with room in pipeline");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> valid_q[0])
    else $error("accepted transfer lost at first stage");
`endif

endmodule
